[sv/mas_pkg.sv]
// ----------------------------------------------------------------------------
// mas_pkg: shared types and constants of the averaging scaler
// Command codes, scale factors, sequencer states and the control/status
// structs between the sequencer and the shared arithmetic unit.
// ----------------------------------------------------------------------------
package mas_pkg;

   localparam int CHANNELS_DEFAULT = 11;

   localparam int CMD_W   = 2;
   localparam int CHAN_W  = 4;
   localparam int DATA_W  = 16;
   localparam int SUM_W   = 32;
   localparam int K_W     = 14;
   localparam int PROD_W  = SUM_W + K_W;        // 46
   localparam int DEN_W   = DATA_W + 13;        // count times 13-bit factor
   localparam int QUO_W   = 17;                 // quotient clipped to 17 bits
   localparam int DIV_STEPS = QUO_W;
   localparam int STEP_W  = 5;

   localparam logic [DATA_W-1:0] AVG_MS_RESET = 16'd255;
   localparam logic [DATA_W-1:0] MAX16        = 16'hFFFF;

   // scale factors: millivolts = sum*12100/(count*5461),
   // milliamps = sum*550/(count*273)
   localparam logic [K_W-1:0] K_MV_NUM = 14'd12100;
   localparam logic [K_W-1:0] K_MV_DEN = 14'd5461;
   localparam logic [K_W-1:0] K_MA_NUM = 14'd550;
   localparam logic [K_W-1:0] K_MA_DEN = 14'd273;

   localparam logic [CMD_W-1:0] CMD_SAMPLE      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK        = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD_OFFSET = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SMP_READ,
      ST_SMP_WRITE,
      ST_TK_READ,
      ST_TK_MUL_NUM,
      ST_TK_MUL_DEN,
      ST_TK_OVF,
      ST_TK_DIV,
      ST_TK_EMIT
   } state_type;

   typedef enum logic [2:0] {
      ARITH_HOLD,
      ARITH_MUL_NUM,
      ARITH_MUL_DEN,
      ARITH_OVF_CHECK,
      ARITH_DIV_STEP
   } arith_op_type;

   typedef struct packed {
      arith_op_type op;
      logic         is_volt;
   } arith_ctrl_type;

   typedef struct packed {
      logic             ovf;
      logic             div_done;
      logic [QUO_W-1:0] quotient;
   } arith_status_type;

endpackage

[sv/mas_arith.sv]
// ----------------------------------------------------------------------------
// mas_arith: shared multiply / compare-subtract unit
// One 32x14 multiplier forms numerator and denominator in turn; one wide
// compare-subtract does the overflow check and the restoring division steps.
// ----------------------------------------------------------------------------
module mas_arith
   import mas_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  arith_ctrl_type       ctrl,
   input  logic [SUM_W-1:0]     opd_sum,
   input  logic [DATA_W-1:0]    opd_count,
   output arith_status_type     status
);

   logic [SUM_W-1:0]  mul_a;
   logic [K_W-1:0]    mul_b;
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] cmp_b;
   logic [PROD_W:0]   diff;
   logic              ge;

   logic [PROD_W-1:0] num_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [PROD_W-1:0] dsh_ff;
   logic [QUO_W-1:0]  q_ff;
   logic [STEP_W-1:0] div_cnt_ff;

   always_comb begin
      if (ctrl.op == ARITH_MUL_DEN) begin
         mul_a = {{(SUM_W-DATA_W){1'b0}}, opd_count};
         mul_b = ctrl.is_volt ? K_MV_DEN : K_MA_DEN;
      end else begin
         mul_a = opd_sum;
         mul_b = ctrl.is_volt ? K_MV_NUM : K_MA_NUM;
      end
   end

   assign prod  = mul_a * mul_b;

   // overflow check compares against den << 17, division steps against dsh
   assign cmp_b = (ctrl.op == ARITH_OVF_CHECK) ? {den_ff, {QUO_W{1'b0}}} : dsh_ff;
   assign diff  = {1'b0, num_ff} - {1'b0, cmp_b};
   assign ge    = ~diff[PROD_W];

   always_ff @(posedge clock) begin
      unique case (ctrl.op)
         ARITH_HOLD: begin
         end
         ARITH_MUL_NUM: begin
            num_ff <= prod;
         end
         ARITH_MUL_DEN: begin
            den_ff <= prod[DEN_W-1:0];
         end
         ARITH_OVF_CHECK: begin
            q_ff   <= ge ? {QUO_W{1'b1}} : {QUO_W{1'b0}};
            dsh_ff <= {1'b0, den_ff, {(QUO_W-1){1'b0}}};
         end
         ARITH_DIV_STEP: begin
            if (ge) begin
               num_ff <= diff[PROD_W-1:0];
            end
            q_ff   <= {q_ff[QUO_W-2:0], ge};
            dsh_ff <= {1'b0, dsh_ff[PROD_W-1:1]};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (ctrl.op == ARITH_OVF_CHECK) begin
         div_cnt_ff <= '0;
      end else if (ctrl.op == ARITH_DIV_STEP) begin
         div_cnt_ff <= div_cnt_ff + STEP_W'(1);
      end
   end

   assign status.ovf      = ge;
   assign status.div_done = (div_cnt_ff == STEP_W'(DIV_STEPS - 1));
   assign status.quotient = q_ff;

endmodule

[sv/multichannel_averaging_scaler.sv]
// ----------------------------------------------------------------------------
// multichannel_averaging_scaler: per-channel boxcar averaging with scaling
// Sums converter samples per channel and, at the end of each averaging
// period, reports every channel's scaled mean (mA or mV, saturated).
// ----------------------------------------------------------------------------
// Latency/throughput: a valid sample is accepted, read and written back, and no
//   new item is taken meanwhile; any other item, or a tick that ends no period,
//   is done in its accept cycle. A reporting tick is accepted, then walks all
//   channels through the shared arithmetic unit: read, 2 multiplies, overflow
//   check, 17 division steps and emit for a channel with samples; no division
//   if the check saturates; read, multiply, emit if empty; output stalls wait.
// Reset (synchronous, active high) clears all sums, counts, offsets and the
//   elapsed counter, and sets the period to 255 ms. No clearing pass.
// ----------------------------------------------------------------------------
module multichannel_averaging_scaler
   import mas_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
)
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     csr_wr_en,
   input  logic [DATA_W-1:0]        csr_wr_data,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CMD_W-1:0]         req_command,
   input  logic [CHAN_W-1:0]        req_channel,
   input  logic [DATA_W-1:0]        req_sample_value,
   input  logic                     req_sample_valid,
   input  logic signed [DATA_W-1:0] req_offset_value,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [CHAN_W-1:0]        rsp_out_channel,
   output logic [DATA_W-1:0]        rsp_value,
   output logic                     rsp_no_samples,
   output logic                     rsp_last
);

   localparam int IDX_W = $clog2(CHANNELS);

   // ---- sequencer and control registers ----
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  addr_ff, addr_in;
   logic [DATA_W-1:0] elapsed_ff, elapsed_in;
   logic [DATA_W-1:0] avg_ms_ff;
   logic [DATA_W-1:0] sval_ff;

   // ---- per-channel storage; valid bits stand in for the zero reset ----
   logic [SUM_W-1:0]         sum_mem_ff [CHANNELS];
   logic [DATA_W-1:0]        cnt_mem_ff [CHANNELS];
   logic signed [DATA_W-1:0] off_mem_ff [CHANNELS];
   logic [CHANNELS-1:0]      smp_vld_ff;
   logic [CHANNELS-1:0]      off_vld_ff;

   // registered read port, one address (addr_ff)
   logic [SUM_W-1:0]         rd_sum_ff;
   logic [DATA_W-1:0]        rd_cnt_ff;
   logic signed [DATA_W-1:0] rd_off_ff;
   logic                     rd_smp_vld_ff;
   logic                     rd_off_vld_ff;

   logic [SUM_W-1:0]         sum_rd;
   logic [DATA_W-1:0]        cnt_rd;
   logic signed [DATA_W-1:0] off_rd;

   // ---- result register ----
   logic              rsp_valid_ff;
   logic [CHAN_W-1:0] rsp_chan_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   logic              rsp_empty_ff;
   logic              rsp_last_ff;

   // ---- decoded request and control strobes ----
   logic              req_take;
   logic              chan_ok;
   logic [IDX_W-1:0]  req_idx;
   logic [DATA_W-1:0] el_inc;
   logic              period_end;
   logic              is_volt;
   logic              is_last_chan;
   logic              out_free;
   logic              cnt_zero;

   logic              smp_wr_en;
   logic              smp_clr_en;
   logic              off_wr_en;
   logic              out_load;

   arith_ctrl_type    arith_ctrl;
   arith_status_type  arith_stat;

   logic [DATA_W-1:0]        scaled;
   logic signed [QUO_W+1:0]  ma_sum;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign chan_ok   = (32'(req_channel) < CHANNELS);
   assign req_idx   = req_channel[IDX_W-1:0];

   // elapsed counter saturates; one counter serves all channels since
   // every channel shares the period and all are advanced and cleared together
   assign el_inc     = (elapsed_ff == MAX16) ? elapsed_ff : elapsed_ff + DATA_W'(1);
   assign period_end = (el_inc >= avg_ms_ff);

   assign is_last_chan = (32'(addr_ff) == CHANNELS - 1);
   assign is_volt      = is_last_chan;
   assign out_free     = ~rsp_valid_ff | ~rsp_stall;

   assign sum_rd   = rd_smp_vld_ff ? rd_sum_ff : '0;
   assign cnt_rd   = rd_smp_vld_ff ? rd_cnt_ff : '0;
   assign off_rd   = rd_off_vld_ff ? rd_off_ff : '0;
   assign cnt_zero = (cnt_rd == '0);

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               priority if (req_command == CMD_SAMPLE && req_sample_valid && chan_ok) begin
                  state_in = ST_SMP_READ;
               end else if (req_command == CMD_TICK && period_end) begin
                  state_in = ST_TK_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SMP_READ:   state_in = ST_SMP_WRITE;
         ST_SMP_WRITE:  state_in = ST_IDLE;
         ST_TK_READ:    state_in = ST_TK_MUL_NUM;
         ST_TK_MUL_NUM: state_in = cnt_zero ? ST_TK_EMIT : ST_TK_MUL_DEN;
         ST_TK_MUL_DEN: state_in = ST_TK_OVF;
         ST_TK_OVF:     state_in = arith_stat.ovf ? ST_TK_EMIT : ST_TK_DIV;
         ST_TK_DIV:     state_in = arith_stat.div_done ? ST_TK_EMIT : ST_TK_DIV;
         ST_TK_EMIT: begin
            if (out_free) begin
               state_in = is_last_chan ? ST_IDLE : ST_TK_READ;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // ---- outputs of the sequencer ----
   always_comb begin
      addr_in         = addr_ff;
      elapsed_in      = elapsed_ff;
      smp_wr_en       = 1'b0;
      smp_clr_en      = 1'b0;
      off_wr_en       = 1'b0;
      out_load        = 1'b0;
      arith_ctrl.op      = ARITH_HOLD;
      arith_ctrl.is_volt = is_volt;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               priority if (req_command == CMD_SAMPLE) begin
                  addr_in = req_idx;
               end else if (req_command == CMD_TICK) begin
                  elapsed_in = period_end ? '0 : el_inc;
                  addr_in    = '0;
               end else if (req_command == CMD_LOAD_OFFSET) begin
                  off_wr_en = chan_ok;
               end else begin
                  // unused command: no effect
               end
            end
         end
         ST_SMP_READ: begin
         end
         ST_SMP_WRITE: begin
            // a full count drops the sample
            smp_wr_en = (cnt_rd != MAX16);
         end
         ST_TK_READ: begin
         end
         ST_TK_MUL_NUM:  arith_ctrl.op = ARITH_MUL_NUM;
         ST_TK_MUL_DEN:  arith_ctrl.op = ARITH_MUL_DEN;
         ST_TK_OVF:      arith_ctrl.op = ARITH_OVF_CHECK;
         ST_TK_DIV:      arith_ctrl.op = ARITH_DIV_STEP;
         ST_TK_EMIT: begin
            if (out_free) begin
               out_load   = 1'b1;
               smp_clr_en = 1'b1;
               if (!is_last_chan) begin
                  addr_in = addr_ff + IDX_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // ---- scaling of the quotient ----
   // current channels add the signed offset, then clamp to 0..65535;
   // quotient bit 16 means at least 65536 (or clipped on overflow)
   assign ma_sum = $signed({2'b00, arith_stat.quotient})
                 + {{(QUO_W+2-DATA_W){off_rd[DATA_W-1]}}, off_rd};

   always_comb begin
      priority if (cnt_zero) begin
         scaled = '0;
      end else if (is_volt) begin
         scaled = arith_stat.quotient[QUO_W-1] ? MAX16 : arith_stat.quotient[DATA_W-1:0];
      end else if (ma_sum[QUO_W+1]) begin
         scaled = '0;
      end else if (ma_sum[QUO_W:DATA_W] != '0) begin
         scaled = MAX16;
      end else begin
         scaled = ma_sum[DATA_W-1:0];
      end
   end

   mas_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (arith_ctrl),
      .opd_sum   (sum_rd),
      .opd_count (cnt_rd),
      .status    (arith_stat)
   );

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         addr_ff    <= '0;
         elapsed_ff <= '0;
         avg_ms_ff  <= AVG_MS_RESET;
      end else begin
         state_ff   <= state_in;
         addr_ff    <= addr_in;
         elapsed_ff <= elapsed_in;
         if (csr_wr_en) begin
            avg_ms_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sval_ff <= req_sample_value;
      end
   end

   // ---- storage: write port and registered read port ----
   always_ff @(posedge clock) begin
      if (smp_wr_en) begin
         sum_mem_ff[addr_ff] <= sum_rd + SUM_W'(sval_ff);
         cnt_mem_ff[addr_ff] <= cnt_rd + DATA_W'(1);
      end
      if (off_wr_en) begin
         off_mem_ff[req_idx] <= req_offset_value;
      end
      rd_sum_ff     <= sum_mem_ff[addr_ff];
      rd_cnt_ff     <= cnt_mem_ff[addr_ff];
      rd_off_ff     <= off_mem_ff[addr_ff];
      rd_smp_vld_ff <= smp_vld_ff[addr_ff];
      rd_off_vld_ff <= off_vld_ff[addr_ff];
   end

   // clearing a channel after its report only drops its valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         smp_vld_ff <= '0;
         off_vld_ff <= '0;
      end else begin
         if (smp_wr_en) begin
            smp_vld_ff[addr_ff] <= 1'b1;
         end
         if (smp_clr_en) begin
            smp_vld_ff[addr_ff] <= 1'b0;
         end
         if (off_wr_en) begin
            off_vld_ff[req_idx] <= 1'b1;
         end
      end
   end

   // ---- result register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_chan_ff  <= CHAN_W'(addr_ff);
         rsp_value_ff <= scaled;
         rsp_empty_ff <= cnt_zero;
         rsp_last_ff  <= is_last_chan;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_chan_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_no_samples  = rsp_empty_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

[sv/mas_checker.sv]
// ----------------------------------------------------------------------------
// mas_checker: port-level checks of the averaging scaler
// Watches the result channel and the input stall over time.
// ----------------------------------------------------------------------------
module mas_checker
   import mas_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
)
(
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [CHAN_W-1:0] rsp_out_channel,
   input logic [DATA_W-1:0] rsp_value,
   input logic              rsp_no_samples,
   input logic              rsp_last
);

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value)
         && $stable(rsp_out_channel) && $stable(rsp_last))
      else $error("result changed while stalled");

   // an empty period reports zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_samples |-> rsp_value == '0)
      else $error("empty period with nonzero value");

   // the final item of a tick is the voltage channel
   a_last_chan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_out_channel == CHAN_W'(CHANNELS - 1))
      else $error("last flag on wrong channel");

   // while a tick's report is incomplete no new input item is taken
   a_busy_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("input taken during report sequence");

endmodule

bind multichannel_averaging_scaler mas_checker #(.CHANNELS(CHANNELS)) u_mas_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_channel (rsp_out_channel),
   .rsp_value       (rsp_value),
   .rsp_no_samples  (rsp_no_samples),
   .rsp_last        (rsp_last)
);

[test/tb_multichannel_averaging_scaler.sv]
// ----------------------------------------------------------------------------
// tb_multichannel_averaging_scaler: self-checking bench for the averaging scaler
// Sends converter samples, offset loads and millisecond ticks, keeps its own
// copy of the per-channel sums, counts, timers and offsets, and checks every
// averaged report field by field against that copy or a typed-in pattern.
// ----------------------------------------------------------------------------
module tb_multichannel_averaging_scaler;
   timeunit 1ns;
   timeprecision 1ps;
   import mas_pkg::*;

   localparam int NUM_CH         = CHANNELS_DEFAULT;
   localparam int SETTLE_CYCLES  = 30;       // after the last report, before a CSR write
   localparam int END_CYCLES     = 40;       // quiet time at the end of the run
   localparam int WATCHDOG_LIMIT = 2000;     // cycles with no handshake at all

   localparam logic [CMD_W-1:0]  CMD_UNUSED   = 2'd3;
   localparam logic [DATA_W-1:0] OFF_MOST_NEG = 16'h8000;
   localparam logic [DATA_W-1:0] OFF_MOST_POS = 16'h7FFF;

   // one averaged report as it leaves the block
   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [DATA_W-1:0] value;
      logic              no_samples;
      logic              last;
   } avg_report_type;

   // how a directed row is checked: by the predictor, or by a typed-in pattern
   typedef enum logic [1:0] {
      CHK_MODEL,      // predictor decides
      CHK_QUIET,      // no report may follow
      CHK_ALL_EMPTY,  // every channel reports 0 with no_samples set
      CHK_ONE         // want_ch reports want_val, every other channel is empty
   } row_check_type;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [CHAN_W-1:0] ch;
      logic [DATA_W-1:0] sval;
      logic              svalid;
      logic [DATA_W-1:0] off;
      row_check_type     chk;
      logic [CHAN_W-1:0] want_ch;
      logic [DATA_W-1:0] want_val;
   } dir_row_type;

   // Directed rows, run with a 1 ms period so that every tick reports every
   // channel. Typed values: 65535 is the clipped mean of a full-scale sample
   // on both kinds of channel, 273 raw gives 550 mA, 5461 raw gives 12100 mV.
   localparam int DIR_ROWS = 26;
   dir_row_type dir_table [DIR_ROWS] = '{
      '{CMD_TICK,        4'd0,  16'd0,    1'b0, 16'd0,        CHK_ALL_EMPTY, 4'd0,  16'd0},
      '{CMD_SAMPLE,      4'd0,  MAX16,    1'b1, 16'd0,        CHK_QUIET,     4'd0,  16'd0},
      '{CMD_TICK,        4'd0,  16'd0,    1'b0, 16'd0,        CHK_ONE,       4'd0,  MAX16},
      '{CMD_SAMPLE,      4'd10, MAX16,    1'b1, 16'd0,        CHK_QUIET,     4'd0,  16'd0},
      '{CMD_TICK,        4'd0,  16'd0,    1'b0, 16'd0,        CHK_ONE,       4'd10, MAX16},
      // most negative offset pulls a zero mean below zero: clamps to 0
      '{CMD_LOAD_OFFSET, 4'd0,  16'd0,    1'b0, OFF_MOST_NEG, CHK_QUIET,     4'd0,  16'd0},
      '{CMD_SAMPLE,      4'd0,  16'd0,    1'b1, 16'd0,        CHK_QUIET,     4'd0,  16'd0},
      '{CMD_TICK,        4'd0,  16'd0,    1'b0, 16'd0,        CHK_ONE,       4'd0,  16'd0},
      // sample not marked valid is dropped
      '{CMD_SAMPLE,      4'd0,  16'd1234, 1'b0, 16'd0,        CHK_QUIET,     4'd0,  16'd0},
      '{CMD_TICK,        4'd0,  16'd0,    1'b0, 16'd0,        CHK_ALL_EMPTY, 4'd0,  16'd0},
      '{CMD_LOAD_OFFSET, 4'd0,  16'd0,    1'b0, 16'd0,        CHK_QUIET,     4'd0,  16'd0},
      '{CMD_SAMPLE,      4'd0,  16'd273,  1'b1, 16'd0,        CHK_QUIET,     4'd0,  16'd0},
      '{CMD_TICK,        4'd0,  16'd0,    1'b0, 16'd0,        CHK_ONE,       4'd0,  16'd550},
      '{CMD_SAMPLE,      4'd10, 16'd5461, 1'b1, 16'd0,        CHK_QUIET,     4'd0,  16'd0},
      '{CMD_TICK,        4'd0,  16'd0,    1'b0, 16'd0,        CHK_ONE,       4'd10, 16'd12100},
      // offset on the voltage channel is stored but has no effect
      '{CMD_LOAD_OFFSET, 4'd10, 16'd0,    1'b0, OFF_MOST_POS, CHK_QUIET,     4'd0,  16'd0},
      '{CMD_SAMPLE,      4'd10, 16'd5461, 1'b1, 16'd0,        CHK_QUIET,     4'd0,  16'd0},
      '{CMD_TICK,        4'd0,  16'd0,    1'b0, 16'd0,        CHK_ONE,       4'd10, 16'd12100},
      // out-of-range channel for a sample and a load, then the unused command
      '{CMD_SAMPLE,      4'd11, 16'd500,  1'b1, 16'd0,        CHK_QUIET,     4'd0,  16'd0},
      '{CMD_LOAD_OFFSET, 4'd15, 16'd0,    1'b0, 16'd100,      CHK_QUIET,     4'd0,  16'd0},
      '{CMD_UNUSED,      4'd5,  MAX16,    1'b1, MAX16,        CHK_QUIET,     4'd0,  16'd0},
      '{CMD_TICK,        4'd0,  16'd0,    1'b0, 16'd0,        CHK_ALL_EMPTY, 4'd0,  16'd0},
      // two samples plus the largest offset, left to the predictor
      '{CMD_LOAD_OFFSET, 4'd5,  16'd0,    1'b0, OFF_MOST_POS, CHK_MODEL,     4'd0,  16'd0},
      '{CMD_SAMPLE,      4'd5,  16'd100,  1'b1, 16'd0,        CHK_MODEL,     4'd0,  16'd0},
      '{CMD_SAMPLE,      4'd5,  16'd300,  1'b1, 16'd0,        CHK_MODEL,     4'd0,  16'd0},
      '{CMD_TICK,        4'd0,  16'd0,    1'b0, 16'd0,        CHK_MODEL,     4'd0,  16'd0}
   };

   // ------------------------------------------------------------------------
   // DUT signals
   // ------------------------------------------------------------------------
   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [DATA_W-1:0]        csr_wr_data;
   logic                     req_valid;
   logic                     req_stall;
   logic [CMD_W-1:0]         req_command;
   logic [CHAN_W-1:0]        req_channel;
   logic [DATA_W-1:0]        req_sample_value;
   logic                     req_sample_valid;
   logic signed [DATA_W-1:0] req_offset_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [CHAN_W-1:0]        rsp_out_channel;
   logic [DATA_W-1:0]        rsp_value;
   logic                     rsp_no_samples;
   logic                     rsp_last;

   multichannel_averaging_scaler #(
      .CHANNELS (NUM_CH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_channel      (req_channel),
      .req_sample_value (req_sample_value),
      .req_sample_valid (req_sample_valid),
      .req_offset_value (req_offset_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_value        (rsp_value),
      .rsp_no_samples   (rsp_no_samples),
      .rsp_last         (rsp_last)
   );

   // ------------------------------------------------------------------------
   // Shadow state of the block and the reports it still owes
   // ------------------------------------------------------------------------
   logic [SUM_W-1:0]         acc_sum    [NUM_CH];
   logic [DATA_W-1:0]        acc_count  [NUM_CH];
   logic [DATA_W-1:0]        ms_elapsed [NUM_CH];
   logic signed [DATA_W-1:0] cal_offset [NUM_CH];
   logic [DATA_W-1:0]        period_ms;

   avg_report_type pending_reports [$];

   bit idle_on;           // random gaps on both channels
   int n_items;
   int n_results;
   int n_errors;
   int quiet_cycles;

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor: applies one accepted item to the shadow state and queues the
   // reports a tick causes. With use_model clear the state still advances
   // but the reports come from a typed-in pattern instead.
   // ------------------------------------------------------------------------
   task automatic predict_averages(input logic [CMD_W-1:0]  cmd,
                                   input logic [CHAN_W-1:0] ch,
                                   input logic [DATA_W-1:0] sval,
                                   input logic              svalid,
                                   input logic [DATA_W-1:0] off,
                                   input bit                use_model);
      avg_report_type    found [$];
      avg_report_type    rep;
      logic [63:0]       num;
      logic [63:0]       den;
      logic [63:0]       quo;
      logic signed [63:0] ma;
      case (cmd)
         CMD_SAMPLE: begin
            // a full count drops the sample, so the sum never wraps
            if (svalid && ch < NUM_CH && acc_count[ch] != MAX16) begin
               acc_sum[ch]   += SUM_W'(sval);
               acc_count[ch] += 1'b1;
            end
         end
         CMD_LOAD_OFFSET: begin
            if (ch < NUM_CH)
               cal_offset[ch] = off;
         end
         CMD_TICK: begin
            for (int c = 0; c < NUM_CH; c++) begin
               if (ms_elapsed[c] != MAX16)
                  ms_elapsed[c] += 1'b1;
               // a zero period makes every tick report
               if (ms_elapsed[c] >= period_ms) begin
                  rep.channel    = CHAN_W'(c);
                  rep.no_samples = (acc_count[c] == '0);
                  rep.last       = 1'b0;
                  if (rep.no_samples) begin
                     rep.value = '0;
                  end else if (c == NUM_CH - 1) begin
                     // voltage channel, offset not applied
                     num = 64'(acc_sum[c]) * 64'(K_MV_NUM);
                     den = 64'(acc_count[c]) * 64'(K_MV_DEN);
                     quo = num / den;
                     rep.value = (quo > 64'(MAX16)) ? MAX16 : quo[DATA_W-1:0];
                  end else begin
                     num = 64'(acc_sum[c]) * 64'(K_MA_NUM);
                     den = 64'(acc_count[c]) * 64'(K_MA_DEN);
                     quo = num / den;
                     ma  = signed'(quo) + cal_offset[c];
                     if (ma < 0)
                        rep.value = '0;
                     else if (ma > 64'sd65535)
                        rep.value = MAX16;
                     else
                        rep.value = ma[DATA_W-1:0];
                  end
                  found.push_back(rep);
                  acc_sum[c]    = '0;
                  acc_count[c]  = '0;
                  ms_elapsed[c] = '0;
               end
            end
            if (found.size() > 0)
               found[found.size()-1].last = 1'b1;
         end
         default: ;   // unused command: no effect
      endcase
      if (use_model)
         foreach (found[k]) pending_reports.push_back(found[k]);
   endtask

   // ------------------------------------------------------------------------
   // Request driver. Entered at a falling edge, leaves at the falling edge
   // after the item was taken, with valid still high, so back-to-back items
   // keep valid up without a dip.
   // ------------------------------------------------------------------------
   task automatic drive_item(input logic [CMD_W-1:0]  cmd,
                             input logic [CHAN_W-1:0] ch,
                             input logic [DATA_W-1:0] sval,
                             input logic              svalid,
                             input logic [DATA_W-1:0] off,
                             input bit                use_model);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_channel      <= ch;
      req_sample_value <= sval;
      req_sample_valid <= svalid;
      req_offset_value <= off;
      // payload holds while stalled
      do @(posedge clock); while (req_stall);
      n_items++;
      predict_averages(cmd, ch, sval, svalid, off, use_model);
      @(negedge clock);
   endtask

   // Period change: only with the block idle, i.e. all reports in and a
   // margin for a sample that may still be writing back.
   task automatic set_period(input logic [DATA_W-1:0] ms);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ms;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      period_ms = ms;
   endtask

   // Random traffic: mostly samples and ticks, with offset loads, bad
   // channels, invalid samples and the odd unused command mixed in.
   task automatic random_phase(input int count);
      logic [CMD_W-1:0]  cmd;
      logic [CHAN_W-1:0] ch;
      logic [DATA_W-1:0] sval;
      logic [DATA_W-1:0] off;
      logic              svalid;
      int                pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         ch   = CHAN_W'($urandom_range(0, NUM_CH - 1));
         if ($urandom_range(0, 15) == 0)
            ch = CHAN_W'($urandom_range(NUM_CH, 15));
         // small values keep current means clear of the 65535 clip
         sval   = ($urandom_range(0, 2) == 0) ? DATA_W'($urandom_range(0, 400))
                                              : DATA_W'($urandom);
         svalid = ($urandom_range(0, 7) != 0);
         case ($urandom_range(0, 4))
            0:       off = OFF_MOST_NEG;
            1:       off = OFF_MOST_POS;
            2:       off = DATA_W'($urandom);
            default: off = DATA_W'($urandom_range(0, 400)) - 16'd200;
         endcase
         if (pick < 55)
            cmd = CMD_SAMPLE;
         else if (pick < 66)
            cmd = CMD_LOAD_OFFSET;
         else if (pick < 97)
            cmd = CMD_TICK;
         else
            cmd = CMD_UNUSED;
         drive_item(cmd, ch, sval, svalid, off, 1'b1);
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side: random stall bursts, changed at the falling edge only.
   // ------------------------------------------------------------------------
   initial begin : rsp_stall_gen
      int left;
      rsp_stall = 1'b0;
      left      = 0;
      forever begin
         @(negedge clock);
         if (left > 0) begin
            left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            left = $urandom_range(1, 5) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Report checker: each accepted report against the oldest one owed
   always @(posedge clock) begin : check_reports
      avg_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (pending_reports.size() == 0) begin
            $error("unexpected report: channel %0d value %0d", rsp_out_channel, rsp_value);
            n_errors++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_out_channel !== want.channel) begin
               $error("out_channel: expected %0d, actual %0d", want.channel, rsp_out_channel);
               n_errors++;
            end
            if (rsp_value !== want.value) begin
               $error("value: expected %0d, actual %0d", want.value, rsp_value);
               n_errors++;
            end
            if (rsp_no_samples !== want.no_samples) begin
               $error("no_samples: expected %0d, actual %0d", want.no_samples,
                      rsp_no_samples);
               n_errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_last);
               n_errors++;
            end
         end
      end
   end

   // Watchdog: any handshake on either side restarts the count
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no handshake for %0d cycles, %0d reports still owed",
                   quiet_cycles, pending_reports.size());
            $display("** multichannel_averaging_scaler: FAILED **");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      avg_report_type rep;
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_valid        = 1'b0;
      req_command      = CMD_SAMPLE;
      req_channel      = '0;
      req_sample_value = '0;
      req_sample_valid = 1'b0;
      req_offset_value = '0;
      idle_on          = 1'b1;
      n_items          = 0;
      n_results        = 0;
      n_errors         = 0;
      quiet_cycles     = 0;
      for (int c = 0; c < NUM_CH; c++) begin
         acc_sum[c]    = '0;
         acc_count[c]  = '0;
         ms_elapsed[c] = '0;
         cal_offset[c] = '0;
      end
      period_ms = AVG_MS_RESET;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset period: the first few ticks report nothing
      drive_item(CMD_SAMPLE, 4'd2, 16'd1000, 1'b1, 16'd0, 1'b1);
      drive_item(CMD_SAMPLE, 4'd10, 16'd3000, 1'b1, 16'd0, 1'b1);
      repeat (3) drive_item(CMD_TICK, 4'd0, 16'd0, 1'b0, 16'd0, 1'b1);

      // shortest nonzero period; one tick flushes the samples above
      set_period(16'd1);
      drive_item(CMD_TICK, 4'd0, 16'd0, 1'b0, 16'd0, 1'b1);

      // directed table
      foreach (dir_table[r]) begin
         if (dir_table[r].chk == CHK_ALL_EMPTY || dir_table[r].chk == CHK_ONE) begin
            for (int c = 0; c < NUM_CH; c++) begin
               rep.channel    = CHAN_W'(c);
               rep.no_samples = !(dir_table[r].chk == CHK_ONE && dir_table[r].want_ch == c);
               rep.value      = rep.no_samples ? '0 : dir_table[r].want_val;
               rep.last       = (c == NUM_CH - 1);
               pending_reports.push_back(rep);
            end
         end
         drive_item(dir_table[r].cmd, dir_table[r].ch, dir_table[r].sval,
                    dir_table[r].svalid, dir_table[r].off, dir_table[r].chk == CHK_MODEL);
      end

      // zero period: every tick reports
      set_period(16'd0);
      random_phase(25);

      // longest period: ticks pile up without a report
      set_period(MAX16);
      random_phase(15);

      set_period(16'd3);
      random_phase(45);
      set_period(16'd2);
      random_phase(35);

      // final stretch with no gaps on either side
      idle_on = 1'b0;
      set_period(16'd6);
      random_phase(50);

      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);

      $display("covered %0d request items and %0d averaged reports", n_items, n_results);
      $display("periods 255 (reset), 1, 0, 65535, 3, 2, 6 ms; %0d directed rows", DIR_ROWS);
      if (n_errors == 0)
         $display("** multichannel_averaging_scaler: PASSED **");
      else
         $display("** multichannel_averaging_scaler: FAILED **");
      $finish;
   end

endmodule

[sim.f]
sv/mas_pkg.sv
sv/mas_arith.sv
sv/multichannel_averaging_scaler.sv
sv/mas_checker.sv
test/tb_multichannel_averaging_scaler.sv
